>>> rtl/eatrm_pkg.sv
// Package for the Euler-angle rotation matrix unit.
// Holds formats, CORDIC arctangent table and shared cell types; no dependencies.
package eatrm_pkg;

	localparam int ANGLE_W         = 16;
	localparam int ELEM_W          = 16;
	localparam int WORK_FRAC       = 30;
	// x, y carry Q30 plus sign and growth headroom
	localparam int XY_W            = 33;
	localparam int Z_W             = 33;
	localparam int ELEM_FRAC_DEF   = 14;
	localparam int TRIG_STAGES_DEF = 16;
	localparam int TRIG_STAGES_MAX = 32;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [17:0] HALF_TURN    = 18'sd23040;
	localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
	// round(2^23/90 * 2^24): multiplier for the degree-to-binary-angle conversion
	localparam int CONV_SHIFT = 24;
	localparam logic [40:0] CONV_MUL = 41'd1563749870615;

	typedef logic signed [XY_W-1:0] xy_t;
	typedef logic signed [Z_W-1:0]  z_t;

	// one CORDIC cell state for one angle
	typedef struct packed {
		xy_t  x;
		xy_t  y;
		z_t   z;
		logic neg;
	} rot_t;

	// three angles travel together through the cell row
	typedef struct packed {
		rot_t a0;
		rot_t a1;
		rot_t a2;
	} trio_t;

	function automatic z_t atan_entry(input int i);
		z_t t;
		case (i)
			0:  t = 33'sd536870912;
			1:  t = 33'sd316933406;
			2:  t = 33'sd167458907;
			3:  t = 33'sd85004756;
			4:  t = 33'sd42667331;
			5:  t = 33'sd21354465;
			6:  t = 33'sd10679838;
			7:  t = 33'sd5340245;
			8:  t = 33'sd2670163;
			9:  t = 33'sd1335087;
			10: t = 33'sd667544;
			11: t = 33'sd333772;
			12: t = 33'sd166886;
			13: t = 33'sd83443;
			14: t = 33'sd41722;
			15: t = 33'sd20861;
			16: t = 33'sd10430;
			17: t = 33'sd5215;
			18: t = 33'sd2608;
			19: t = 33'sd1304;
			20: t = 33'sd652;
			21: t = 33'sd326;
			22: t = 33'sd163;
			23: t = 33'sd81;
			24: t = 33'sd41;
			25: t = 33'sd20;
			26: t = 33'sd10;
			27: t = 33'sd5;
			28: t = 33'sd3;
			29: t = 33'sd1;
			30: t = 33'sd1;
			default: t = 33'sd0;
		endcase
		return t;
	endfunction

endpackage

>>> rtl/eatrm_cell.sv
// One CORDIC rotation cell for three angles side by side.
// Depends on eatrm_pkg.
module eatrm_cell import eatrm_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic  clk,
	input  trio_t d,
	output trio_t q
);

	function automatic rot_t rot_step(input rot_t r);
		rot_t o;
		xy_t  dx;
		xy_t  dy;
		dx = r.y >>> SHIFT;
		dy = r.x >>> SHIFT;
		o.neg = r.neg;
		if (!r.z[Z_W-1]) begin
			o.x = r.x - dx;
			o.y = r.y + dy;
			o.z = r.z - atan_entry(SHIFT);
		end else begin
			o.x = r.x + dx;
			o.y = r.y - dy;
			o.z = r.z + atan_entry(SHIFT);
		end
		return o;
	endfunction

	trio_t cell_q;

	// payload only, no reset
	always_ff @(posedge clk) begin
		cell_q.a0 <= rot_step(d.a0);
		cell_q.a1 <= rot_step(d.a1);
		cell_q.a2 <= rot_step(d.a2);
	end

	assign q = cell_q;

endmodule

>>> rtl/eatrm_prep.sv
// Angle reduction and degree-to-binary-angle conversion, two stages.
// Depends on eatrm_pkg.
module eatrm_prep import eatrm_pkg::*; (
	input  logic                      clk,
	input  logic signed [ANGLE_W-1:0] ang,
	output rot_t                      r
);

	logic [14:0] mag_s1;
	logic        sgn_s1;
	logic        neg_s1;
	rot_t        r_s2;

	logic signed [17:0] a_ext;
	logic signed [17:0] a_red;
	logic               neg_c;
	logic [17:0]        mag_c;
	logic [56:0]        prod;
	logic [30:0]        zmag;

	always_comb begin
		a_ext = 18'(ang);
		neg_c = 1'b0;
		a_red = a_ext;
		if (a_ext > QUARTER_TURN) begin
			a_red = a_ext - HALF_TURN;
			neg_c = 1'b1;
		end else if (a_ext < -QUARTER_TURN) begin
			a_red = a_ext + HALF_TURN;
			neg_c = 1'b1;
		end
		mag_c = a_red[17] ? 18'(-a_red) : a_red;
	end

	always_ff @(posedge clk) begin
		mag_s1 <= mag_c[14:0];
		sgn_s1 <= a_red[17];
		neg_s1 <= neg_c;
	end

	// round(mag*2^23/90): exact for mag <= 11520 with this reciprocal
	always_comb begin
		prod = 57'(mag_s1) * 57'(CONV_MUL) + (57'd1 << (CONV_SHIFT - 1));
		zmag = prod[CONV_SHIFT +: 31];
	end

	always_ff @(posedge clk) begin
		r_s2.x   <= CORDIC_GAIN;
		r_s2.y   <= '0;
		r_s2.z   <= sgn_s1 ? -z_t'(zmag) : z_t'(zmag);
		r_s2.neg <= neg_s1;
	end

	assign r = r_s2;

endmodule

>>> rtl/eatrm_matrix.sv
// Matrix product stages: pair products, triple products, sums and output rounding.
// Depends on eatrm_pkg.
module eatrm_matrix import eatrm_pkg::*; #(
	parameter int ELEM_FRAC_BITS = ELEM_FRAC_DEF
) (
	input  logic                     clk,
	input  xy_t                      cx,
	input  xy_t                      sx,
	input  xy_t                      cy,
	input  xy_t                      sy,
	input  xy_t                      cz,
	input  xy_t                      sz,
	output logic signed [ELEM_W-1:0] m [9]
);

	localparam int RS = WORK_FRAC - ELEM_FRAC_BITS;

	function automatic xy_t mulq(input xy_t a, input xy_t b);
		logic signed [2*XY_W-1:0] p;
		p = a * b + (66'sd1 <<< (WORK_FRAC - 1));
		return xy_t'(p >>> WORK_FRAC);
	endfunction

	function automatic logic signed [ELEM_W-1:0] to_field(input logic signed [XY_W+1:0] v);
		logic signed [XY_W+1:0] r;
		logic signed [XY_W+1:0] one;
		one = 35'sd1 <<< ELEM_FRAC_BITS;
		r = (v + (35'sd1 <<< (RS - 1))) >>> RS;
		if (r > one)  r = one;
		if (r < -one) r = -one;
		if (r > 35'sd32767)  r = 35'sd32767;
		if (r < -35'sd32768) r = -35'sd32768;
		return r[ELEM_W-1:0];
	endfunction

	// stage 1: pair products
	xy_t czcy_s1, szsx_s1, szcx_s1, czsy_s1, szcy_s1, czsx_s1, czcx_s1, szsy_s1;
	xy_t cxsy_s1, cxcy_s1, sx_s1, sy_s1, cy_s1;
	always_ff @(posedge clk) begin
		czcy_s1 <= mulq(cz, cy);
		szsx_s1 <= mulq(sz, sx);
		szcx_s1 <= mulq(sz, cx);
		czsy_s1 <= mulq(cz, sy);
		szcy_s1 <= mulq(sz, cy);
		czsx_s1 <= mulq(cz, sx);
		czcx_s1 <= mulq(cz, cx);
		szsy_s1 <= mulq(sz, sy);
		cxsy_s1 <= mulq(cx, sy);
		cxcy_s1 <= mulq(cx, cy);
		sx_s1   <= sx;
		sy_s1   <= sy;
		cy_s1   <= cy;
	end

	// stage 2: triple products, hold the rest
	xy_t t0_s2, t2_s2, t3_s2, t5_s2;
	xy_t czcy_s2, szcx_s2, czsy_s2, szcy_s2, czcx_s2, szsy_s2, cxsy_s2, cxcy_s2, sx_s2;
	always_ff @(posedge clk) begin
		t0_s2   <= mulq(szsx_s1, sy_s1);
		t2_s2   <= mulq(szsx_s1, cy_s1);
		t3_s2   <= mulq(czsx_s1, sy_s1);
		t5_s2   <= mulq(czsx_s1, cy_s1);
		czcy_s2 <= czcy_s1;
		szcx_s2 <= szcx_s1;
		czsy_s2 <= czsy_s1;
		szcy_s2 <= szcy_s1;
		czcx_s2 <= czcx_s1;
		szsy_s2 <= szsy_s1;
		cxsy_s2 <= cxsy_s1;
		cxcy_s2 <= cxcy_s1;
		sx_s2   <= sx_s1;
	end

	// stage 3: sums, rounding and saturation
	logic signed [ELEM_W-1:0] m_s3 [9];
	always_ff @(posedge clk) begin
		m_s3[0] <= to_field(35'(czcy_s2) - 35'(t0_s2));
		m_s3[1] <= to_field(-35'(szcx_s2));
		m_s3[2] <= to_field(35'(czsy_s2) + 35'(t2_s2));
		m_s3[3] <= to_field(35'(szcy_s2) + 35'(t3_s2));
		m_s3[4] <= to_field(35'(czcx_s2));
		m_s3[5] <= to_field(35'(szsy_s2) - 35'(t5_s2));
		m_s3[6] <= to_field(-35'(cxsy_s2));
		m_s3[7] <= to_field(35'(sx_s2));
		m_s3[8] <= to_field(35'(cxcy_s2));
	end

	assign m = m_s3;

endmodule

>>> rtl/euler_angles_to_rotation_matrix_unit.sv
// Top level of the Euler-angle rotation matrix unit: prep, CORDIC cell row, matrix.
// Depends on eatrm_pkg, eatrm_prep, eatrm_cell, eatrm_matrix.
//
//  channel | ports                                | handshake
//  --------+--------------------------------------+------------------------------
//  angles  | yaw_deg, pitch_deg, roll_deg         | start while busy low
//  matrix  | elem_r0c0 .. elem_r2c2               | done strobe, one cycle
//
// One item enters per cycle; busy stays low, the pipeline never stops.
// Items pass through angle reduction and conversion, then the CORDIC cell row,
// a sign fix-up register and the matrix product stages.
// Reset clears only the valid row; payload registers flush naturally.
// The receiver cannot stall: done marks each matrix for exactly one cycle.
module euler_angles_to_rotation_matrix_unit import eatrm_pkg::*; #(
	parameter int ELEM_FRAC_BITS = ELEM_FRAC_DEF,
	parameter int TRIG_STAGES    = TRIG_STAGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [ANGLE_W-1:0] yaw_deg,
	input  logic signed [ANGLE_W-1:0] pitch_deg,
	input  logic signed [ANGLE_W-1:0] roll_deg,
	output logic                      done,
	output logic signed [ELEM_W-1:0]  elem_r0c0,
	output logic signed [ELEM_W-1:0]  elem_r0c1,
	output logic signed [ELEM_W-1:0]  elem_r0c2,
	output logic signed [ELEM_W-1:0]  elem_r1c0,
	output logic signed [ELEM_W-1:0]  elem_r1c1,
	output logic signed [ELEM_W-1:0]  elem_r1c2,
	output logic signed [ELEM_W-1:0]  elem_r2c0,
	output logic signed [ELEM_W-1:0]  elem_r2c1,
	output logic signed [ELEM_W-1:0]  elem_r2c2
);

	localparam int LATENCY = TRIG_STAGES + 6;

	assign busy = 1'b0;

	// angle preparation, one unit per angle
	trio_t chain [TRIG_STAGES+1];
	eatrm_prep u_prep_yaw   (.clk(clk), .ang(yaw_deg),   .r(chain[0].a0));
	eatrm_prep u_prep_pitch (.clk(clk), .ang(pitch_deg), .r(chain[0].a1));
	eatrm_prep u_prep_roll  (.clk(clk), .ang(roll_deg),  .r(chain[0].a2));

	// row of CORDIC cells; each hands its three rotations to the next every cycle
	for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
		eatrm_cell #(.SHIFT(g)) u_cell (.clk(clk), .d(chain[g]), .q(chain[g+1]));
	end

	// apply the half-turn negation left over from reduction
	xy_t cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;
	always_ff @(posedge clk) begin
		cx_s1 <= chain[TRIG_STAGES].a0.neg ? -chain[TRIG_STAGES].a0.x : chain[TRIG_STAGES].a0.x;
		sx_s1 <= chain[TRIG_STAGES].a0.neg ? -chain[TRIG_STAGES].a0.y : chain[TRIG_STAGES].a0.y;
		cy_s1 <= chain[TRIG_STAGES].a1.neg ? -chain[TRIG_STAGES].a1.x : chain[TRIG_STAGES].a1.x;
		sy_s1 <= chain[TRIG_STAGES].a1.neg ? -chain[TRIG_STAGES].a1.y : chain[TRIG_STAGES].a1.y;
		cz_s1 <= chain[TRIG_STAGES].a2.neg ? -chain[TRIG_STAGES].a2.x : chain[TRIG_STAGES].a2.x;
		sz_s1 <= chain[TRIG_STAGES].a2.neg ? -chain[TRIG_STAGES].a2.y : chain[TRIG_STAGES].a2.y;
	end

	logic signed [ELEM_W-1:0] m [9];
	eatrm_matrix #(.ELEM_FRAC_BITS(ELEM_FRAC_BITS)) u_matrix (
		.clk(clk), .cx(cx_s1), .sx(sx_s1), .cy(cy_s1), .sy(sy_s1),
		.cz(cz_s1), .sz(sz_s1), .m(m)
	);

	// valid row tracks items alongside the payload
	logic [LATENCY-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start};
		end
	end

	assign done      = vld_q[LATENCY-1];
	assign elem_r0c0 = m[0];
	assign elem_r0c1 = m[1];
	assign elem_r0c2 = m[2];
	assign elem_r1c0 = m[3];
	assign elem_r1c1 = m[4];
	assign elem_r1c2 = m[5];
	assign elem_r2c0 = m[6];
	assign elem_r2c1 = m[7];
	assign elem_r2c2 = m[8];

endmodule

>>> rtl/eatrm_checker.sv
// Port-level checker for the rotation matrix unit, bound to the top level.
// Depends on eatrm_pkg and euler_angles_to_rotation_matrix_unit.
module eatrm_checker import eatrm_pkg::*; #(
	parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     start,
	input logic                     busy,
	input logic                     done,
	input logic signed [ELEM_W-1:0] elem_r2c1,
	input logic signed [ELEM_W-1:0] elem_r0c0
);

	localparam int LAT = TRIG_STAGES + 6;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done) else $error("item lost");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##LAT !done) else $error("item invented");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (elem_r2c1 <= 16'sd16384 && elem_r2c1 >= -16'sd16384
			&& elem_r0c0 <= 16'sd16384 && elem_r0c0 >= -16'sd16384))
		else $error("element out of range");

endmodule

bind euler_angles_to_rotation_matrix_unit eatrm_checker #(.TRIG_STAGES(TRIG_STAGES)) u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.elem_r2c1(elem_r2c1), .elem_r0c0(elem_r0c0)
);
